// File: rtl/ffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit hole allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int FIELD_BITS       = 24;
  localparam int MAX_HOLES_DEF    = 16;
  localparam int OFFSET_BITS_DEF  = 24;
  localparam int REGION_RESET     = 65536;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    ALU_GE,
    ALU_LT,
    ALU_ADD,
    ALU_SUB,
    ALU_SAT
  } alu_op_t;

  typedef struct packed {
    logic                  operation;
    logic [FIELD_BITS-1:0] block_size;
    logic [FIELD_BITS-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FIELD_BITS-1:0] block_offset;
  } rsp_t;

endpackage
`default_nettype wire

// File: rtl/ffa_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_table
// Hole table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffa_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 48
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/ffa_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_alu
// Shared add, subtract and compare unit used by the allocator sequencer.
// ----------------------------------------------------------------------------
module ffa_alu #(
  parameter int OW = 24
) (
  input  ffa_pkg::alu_op_t  op,
  input  wire logic [OW-1:0] a,
  input  wire logic [OW-1:0] b,
  input  wire logic [OW-1:0] c,
  output logic      [OW-1:0] res,
  output logic               flag
);

  import ffa_pkg::*;

  logic [OW:0]   sum;
  logic [OW-1:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = a - b;

  always_comb begin
    res  = '0;
    flag = 1'b0;
    case (op)
      ALU_GE: begin
        flag = (a >= b);
      end
      ALU_LT: begin
        flag = (a < b);
      end
      ALU_ADD: begin
        res  = sum[OW-1:0];
        flag = (sum == {1'b0, c});
      end
      ALU_SUB: begin
        res  = diff;
        flag = (diff == '0);
      end
      ALU_SAT: begin
        res = sum[OW] ? '1 : sum[OW-1:0];
      end
      default: begin
        res  = '0;
        flag = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/first_fit_hole_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_hole_allocator
// Keeps a sorted table of free holes; allocates first fit and frees with
// coalescing of contiguous holes.
// ----------------------------------------------------------------------------
// sequence: allocate reads and compares holes until one fits, then adds and
//   subtracts to update that hole and moves later entries down when it
//   empties; free scans for the insert point, shifts entries up to insert,
//   then checks each neighbor pair and merges contiguous ones, removing the
//   merged entry; the response is handed off from idle
// throughput: one word at a time, set by the 1R1W table and the shared alu
// reset: synchronous; the S_INIT state after reset loads the initial hole
// ----------------------------------------------------------------------------
module first_fit_hole_allocator #(
  parameter int MAX_HOLES   = ffa_pkg::MAX_HOLES_DEF,
  parameter int OFFSET_BITS = ffa_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  ffa_pkg::req_t                         req,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output ffa_pkg::rsp_t                         rsp,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ffa_pkg::FIELD_BITS-1:0]   cfg_data
);

  import ffa_pkg::*;

  localparam int OW = OFFSET_BITS;
  localparam int CW = $clog2(MAX_HOLES + 1);
  localparam int IW = $clog2(MAX_HOLES);
  localparam int DW = 2 * OW;
  localparam logic [OW-1:0] REGION_INIT = OW'(REGION_RESET);
  localparam logic [CW-1:0] FULL_COUNT  = CW'(MAX_HOLES);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_RD,
    S_A_CMP,
    S_A_ADD,
    S_A_SUB,
    S_DR,
    S_DR_WR,
    S_F_RD,
    S_F_CMP,
    S_SH,
    S_SH_WR,
    S_C_CHK,
    S_C_RDB,
    S_C_CMP,
    S_C_MRG
  } state_t;

  state_t state;
  state_t state_done;

  logic          op;
  logic [OW-1:0] size;
  logic [OW-1:0] where_off;
  logic [CW-1:0] idx;
  logic [CW-1:0] k;
  logic [CW-1:0] count;
  logic [OW-1:0] a_start;
  logic [OW-1:0] a_len;
  logic [OW-1:0] b_len;
  logic [OW-1:0] new_start;
  logic [OW-1:0] off;
  logic [1:0]    status;
  logic          pending;
  logic          rsp_load;

  logic          we;
  logic [IW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [DW-1:0] rdata;
  logic [OW-1:0] rstart;
  logic [OW-1:0] rlen;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] k_dec;
  logic [CW-1:0] idx_inc;

  alu_op_t       alu_op;
  logic [OW-1:0] alu_a;
  logic [OW-1:0] alu_b;
  logic [OW-1:0] alu_c;
  logic [OW-1:0] alu_res;
  logic          alu_flag;

  logic [OW-1:0] req_size;
  logic [OW-1:0] req_where;
  logic [OW-1:0] cfg_region;

  assign state_done = S_IDLE;

  assign rstart     = rdata[DW-1:OW];
  assign rlen       = rdata[OW-1:0];
  assign k_inc      = k + 1'b1;
  assign k_dec      = k - 1'b1;
  assign idx_inc    = idx + 1'b1;
  assign req_size   = OW'(req.block_size);
  assign req_where  = OW'(req.free_offset);
  assign cfg_region = OW'(cfg_data);

  assign req_ready = (state == S_IDLE) && !pending && !cfg_valid;
  assign cfg_ready = (state == S_IDLE) && !pending;
  assign rsp_load  = (state == S_IDLE) && pending && (!rsp_valid || rsp_ready);

  ffa_table #(
    .DEPTH (MAX_HOLES),
    .AW    (IW),
    .DW    (DW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ffa_alu #(
    .OW (OW)
  ) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .c    (alu_c),
    .res  (alu_res),
    .flag (alu_flag)
  );

  // table port and alu operand selection
  always_comb begin
    we     = 1'b0;
    waddr  = '0;
    wdata  = '0;
    raddr  = '0;
    alu_op = ALU_GE;
    alu_a  = '0;
    alu_b  = '0;
    alu_c  = '0;
    case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = {{OW{1'b0}}, REGION_INIT};
      end
      S_IDLE: begin
        if (cfg_valid && !pending) begin
          we    = 1'b1;
          wdata = {{OW{1'b0}}, cfg_region};
        end
      end
      S_A_RD: begin
        raddr = idx[IW-1:0];
      end
      S_A_CMP: begin
        alu_op = ALU_GE;
        alu_a  = rlen;
        alu_b  = size;
      end
      S_A_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = a_start;
        alu_b  = size;
      end
      S_A_SUB: begin
        alu_op = ALU_SUB;
        alu_a  = a_len;
        alu_b  = size;
        if (!alu_flag) begin
          we    = 1'b1;
          waddr = idx[IW-1:0];
          wdata = {new_start, alu_res};
        end
      end
      S_DR: begin
        raddr = k_inc[IW-1:0];
      end
      S_DR_WR: begin
        we    = 1'b1;
        waddr = k[IW-1:0];
        wdata = rdata;
      end
      S_F_RD: begin
        raddr = idx[IW-1:0];
      end
      S_F_CMP: begin
        alu_op = ALU_LT;
        alu_a  = rstart;
        alu_b  = where_off;
      end
      S_SH: begin
        raddr = k_dec[IW-1:0];
        if (k <= idx) begin
          we    = 1'b1;
          waddr = idx[IW-1:0];
          wdata = {where_off, size};
        end
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = k[IW-1:0];
        wdata = rdata;
      end
      S_C_CHK: begin
        raddr = idx[IW-1:0];
      end
      S_C_RDB: begin
        raddr = idx_inc[IW-1:0];
      end
      S_C_CMP: begin
        alu_op = ALU_ADD;
        alu_a  = a_start;
        alu_b  = a_len;
        alu_c  = rstart;
      end
      S_C_MRG: begin
        alu_op = ALU_SAT;
        alu_a  = a_len;
        alu_b  = b_len;
        we     = 1'b1;
        waddr  = idx[IW-1:0];
        wdata  = {a_start, alu_res};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= '0;
      pending   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          count <= CW'(REGION_INIT != '0);
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (pending) begin
            if (rsp_load) begin
              rsp_valid         <= 1'b1;
              rsp.status        <= status;
              rsp.block_offset  <= FIELD_BITS'(off);
              pending           <= 1'b0;
            end
          end else if (cfg_valid) begin
            count <= CW'(cfg_region != '0);
          end else if (req_valid) begin
            op        <= req.operation;
            size      <= req_size;
            where_off <= req_where;
            idx       <= '0;
            off       <= '0;
            status    <= ST_OK;
            if (req.operation == OP_ALLOC) begin
              if (count == '0) begin
                status  <= ST_NO_FIT;
                pending <= 1'b1;
              end else begin
                state <= S_A_RD;
              end
            end else if (req_size == '0) begin
              pending <= 1'b1;
            end else if (count == FULL_COUNT) begin
              status  <= ST_FULL;
              pending <= 1'b1;
            end else begin
              state <= S_F_RD;
            end
          end
        end
        S_A_RD: begin
          state <= S_A_CMP;
        end
        S_A_CMP: begin
          if (alu_flag) begin
            a_start <= rstart;
            a_len   <= rlen;
            off     <= rstart;
            if (size == '0) begin
              pending <= 1'b1;
              state   <= state_done;
            end else begin
              state <= S_A_ADD;
            end
          end else if (idx_inc >= count) begin
            status  <= ST_NO_FIT;
            pending <= 1'b1;
            state   <= state_done;
          end else begin
            idx   <= idx_inc;
            state <= S_A_RD;
          end
        end
        S_A_ADD: begin
          new_start <= alu_res;
          state     <= S_A_SUB;
        end
        S_A_SUB: begin
          if (alu_flag) begin
            k     <= idx;
            state <= S_DR;
          end else begin
            pending <= 1'b1;
            state   <= state_done;
          end
        end
        S_DR: begin
          if (k_inc < count) begin
            state <= S_DR_WR;
          end else begin
            count <= count - 1'b1;
            if (op == OP_FREE) begin
              state <= S_C_CHK;
            end else begin
              pending <= 1'b1;
              state   <= state_done;
            end
          end
        end
        S_DR_WR: begin
          k     <= k_inc;
          state <= S_DR;
        end
        S_F_RD: begin
          if (idx == count) begin
            k     <= count;
            state <= S_SH;
          end else begin
            state <= S_F_CMP;
          end
        end
        S_F_CMP: begin
          if (alu_flag) begin
            idx   <= idx_inc;
            state <= S_F_RD;
          end else begin
            k     <= count;
            state <= S_SH;
          end
        end
        S_SH: begin
          if (k > idx) begin
            state <= S_SH_WR;
          end else begin
            count <= count + 1'b1;
            idx   <= '0;
            state <= S_C_CHK;
          end
        end
        S_SH_WR: begin
          k     <= k_dec;
          state <= S_SH;
        end
        S_C_CHK: begin
          if (idx_inc < count) begin
            state <= S_C_RDB;
          end else begin
            pending <= 1'b1;
            state   <= state_done;
          end
        end
        S_C_RDB: begin
          a_start <= rstart;
          a_len   <= rlen;
          state   <= S_C_CMP;
        end
        S_C_CMP: begin
          if (alu_flag) begin
            b_len <= rlen;
            state <= S_C_MRG;
          end else begin
            idx   <= idx_inc;
            state <= S_C_CHK;
          end
        end
        S_C_MRG: begin
          k     <= idx_inc;
          state <= S_DR;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
